// ----- sv/sce_pkg.sv -----
package sce_pkg;

   // field widths
   localparam int CHAN_W  = 4;
   localparam int ANGLE_W = 12;
   localparam int TIME_W  = 16;
   localparam int FRAC_W  = 16;
   localparam int S_W     = FRAC_W + 1;
   localparam int COUNT_W = 12;
   localparam int POS_W   = ANGLE_W + FRAC_W;

   // divider produces one quotient bit per stage, integer bit first
   localparam int DIV_STAGES = FRAC_W + 1;

   // ease polynomial: e = s^2 * (3*2^16 - 2*s) >> 32
   localparam logic [S_W:0]   EASE_THREE = 18'd196608;
   localparam logic [S_W-1:0] ONE_Q16    = 17'd65536;

   // pwm mapping: off = floor(a*474 / (105 * 2^21)) + 73
   localparam logic [8:0]  PWM_SCALE   = 9'd474;
   localparam int          SCALE_SHIFT = 21;
   localparam int          SCALED_W    = 16;
   // reciprocal of 105, exact for any 16-bit dividend
   localparam logic [16:0] RECIP_105   = 17'd79892;
   localparam int          RECIP_SHIFT = 23;
   localparam int          QUOT_W      = 10;
   localparam logic [10:0] PWM_OFFSET  = 11'd73;
   localparam logic [COUNT_W-1:0] PWM_MAX = 12'd4095;

   // per-item context carried alongside the arithmetic
   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [ANGLE_W-1:0] start_ang;
      logic [ANGLE_W-1:0] end_ang;
      logic               done;
      logic               last;
   } sce_side_type;

endpackage

// ----- sv/servo_cubic_ease_to_pwm.sv -----
// Cubic-eased servo position to PWM counts.
//
// req channel: one servo move record per transaction (channel, start and end
// angle in 1/16 degree, duration and elapsed time in ms); req_tlast marks the
// last servo of an update. rsp channel: one transaction per record with the
// channel, on count (always zero) and off count; rsp_tuser flags a finished
// move, rsp_tlast copies req_tlast.
//
// Between an accepted req transaction and rsp_tvalid lie 17 stages of the
// restoring divider (one quotient bit each), 2 stages for the ease polynomial
// (square, then cubic product), and 3 stages for the interpolation, the 474
// scaling and the divide by 105 into the output register. One transaction
// enters per cycle while the output drains.
//
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver holds rsp_tready low, the result stays in the output register and
// upstream stages keep filling until every stage holds an item, after which
// req_tready drops; nothing is dropped or repeated.
module servo_cubic_ease_to_pwm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // servo_channel[3:0], start_angle[15:4], end_angle[27:16],
   // duration_ms[43:28], elapsed_ms[59:44], zero pad
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_channel[3:0], on_count[15:4], off_count[27:16], zero pad
   output logic [31:0] rsp_tdata,
   // reached_end[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import sce_pkg::*;

   logic [TIME_W-1:0]  dur, el;
   sce_side_type       req_side;

   logic               div_valid, div_ready;
   logic [S_W-1:0]     div_s;
   sce_side_type       div_side;

   logic               ease_valid, ease_ready;
   logic [S_W-1:0]     ease_e;
   sce_side_type       ease_side;

   logic [CHAN_W-1:0]  out_chan;
   logic [COUNT_W-1:0] out_off;
   logic               out_done;

   // unpack the request and flag finished moves
   always_comb begin
      dur                = req_tdata[43:28];
      el                 = req_tdata[59:44];
      req_side.chan      = req_tdata[3:0];
      req_side.start_ang = req_tdata[15:4];
      req_side.end_ang   = req_tdata[27:16];
      req_side.done      = (dur == '0) || (el > dur);
      req_side.last      = req_tlast;
   end

   sce_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_dur    (dur),
      .in_el     (el),
      .in_side   (req_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_s     (div_s),
      .out_side  (div_side)
   );

   sce_ease u_ease (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_s      (div_s),
      .in_side   (div_side),
      .out_valid (ease_valid),
      .out_ready (ease_ready),
      .out_e     (ease_e),
      .out_side  (ease_side)
   );

   sce_pwm u_pwm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ease_valid),
      .in_ready  (ease_ready),
      .in_e      (ease_e),
      .in_side   (ease_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_chan  (out_chan),
      .out_off   (out_off),
      .out_done  (out_done),
      .out_last  (rsp_tlast)
   );

   // pack the response, on count is always zero
   assign rsp_tdata = {4'b0000, out_off, {COUNT_W{1'b0}}, out_chan};
   assign rsp_tuser = out_done;

endmodule

// ----- sv/sce_div.sv -----
module sce_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [sce_pkg::TIME_W-1:0]   in_dur,
   input  logic [sce_pkg::TIME_W-1:0]   in_el,
   input  sce_pkg::sce_side_type        in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [sce_pkg::S_W-1:0]      out_s,
   output sce_pkg::sce_side_type        out_side
);
   import sce_pkg::*;

   localparam int N = DIV_STAGES;

   logic               vld_ff  [N];
   logic               vld_in  [N];
   logic               adv     [N];
   logic [TIME_W-1:0]  rem_ff  [N];
   logic [TIME_W-1:0]  rem_in  [N];
   logic [TIME_W-1:0]  dur_ff  [N];
   logic [S_W-1:0]     quo_ff  [N];
   logic [S_W-1:0]     quo_in  [N];
   sce_side_type       side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      // stage moves when empty or when the next one moves
      if (i == N - 1) begin : g_tail
         assign adv[i] = !vld_ff[i] || out_ready;
      end else begin : g_body
         assign adv[i] = !vld_ff[i] || adv[i+1];
      end

      if (i == 0) begin : g_first
         logic [TIME_W:0] diff;

         // integer bit of the quotient: elapsed at or past duration
         always_comb begin
            diff      = {1'b0, in_el} - {1'b0, in_dur};
            vld_in[i] = adv[i] ? in_valid : vld_ff[i];
            quo_in[i] = '0;
            quo_in[i][S_W-1] = !diff[TIME_W];
            rem_in[i] = diff[TIME_W] ? in_el : diff[TIME_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (adv[i]) begin
               rem_ff[i]  <= rem_in[i];
               quo_ff[i]  <= quo_in[i];
               dur_ff[i]  <= in_dur;
               side_ff[i] <= in_side;
            end
         end
      end else begin : g_step
         logic [TIME_W:0]   dbl;
         logic [TIME_W+1:0] diff;

         // one restoring step: shift, trial subtract, keep or restore
         always_comb begin
            dbl       = {rem_ff[i-1], 1'b0};
            diff      = {1'b0, dbl} - {2'b00, dur_ff[i-1]};
            vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
            quo_in[i] = quo_ff[i-1];
            quo_in[i][S_W-1-i] = !diff[TIME_W+1];
            rem_in[i] = diff[TIME_W+1] ? dbl[TIME_W-1:0] : diff[TIME_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (adv[i]) begin
               rem_ff[i]  <= rem_in[i];
               quo_ff[i]  <= quo_in[i];
               dur_ff[i]  <= dur_ff[i-1];
               side_ff[i] <= side_ff[i-1];
            end
         end
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[N-1];
   assign out_s     = quo_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ----- sv/sce_ease.sv -----
module sce_ease (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [sce_pkg::S_W-1:0]   in_s,
   input  sce_pkg::sce_side_type     in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [sce_pkg::S_W-1:0]   out_e,
   output sce_pkg::sce_side_type     out_side
);
   import sce_pkg::*;

   localparam int SQ_W  = 2 * S_W - 1;
   localparam int NUM_W = SQ_W + S_W + 1;
   localparam int RAW_W = NUM_W - 32;

   logic                sq_vld_ff, sq_vld_in, sq_adv;
   logic [SQ_W-1:0]     sq_ff;
   logic [2*S_W-1:0]    sq_in;
   logic [S_W-1:0]      s_ff;
   sce_side_type        sq_side_ff;

   logic                e_vld_ff, e_vld_in, e_adv;
   logic [S_W-1:0]      e_ff, e_in;
   sce_side_type        e_side_ff;
   logic [S_W:0]        weight;
   logic [NUM_W-1:0]    num;
   logic [RAW_W-1:0]    e_raw;

   assign e_adv    = !e_vld_ff || out_ready;
   assign sq_adv   = !sq_vld_ff || e_adv;
   assign in_ready = sq_adv;

   // square of the fraction
   always_comb begin
      sq_in     = {{S_W{1'b0}}, in_s} * {{S_W{1'b0}}, in_s};
      sq_vld_in = sq_adv ? in_valid : sq_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (sq_adv) begin
         sq_ff      <= sq_in[SQ_W-1:0];
         s_ff       <= in_s;
         sq_side_ff <= in_side;
      end
   end

   // s^2 * (3 - 2s), kept as one product before truncation
   always_comb begin
      weight   = EASE_THREE - {s_ff, 1'b0};
      num      = {{(S_W+1){1'b0}}, sq_ff} * {{SQ_W{1'b0}}, weight};
      e_raw    = num[NUM_W-1:32];
      e_in     = (e_raw > RAW_W'(ONE_Q16)) ? ONE_Q16 : e_raw[S_W-1:0];
      e_vld_in = e_adv ? sq_vld_ff : e_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (e_adv) begin
         e_ff      <= e_in;
         e_side_ff <= sq_side_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         e_vld_ff  <= 1'b0;
      end else begin
         sq_vld_ff <= sq_vld_in;
         e_vld_ff  <= e_vld_in;
      end
   end

   assign out_valid = e_vld_ff;
   assign out_e     = e_ff;
   assign out_side  = e_side_ff;

endmodule

// ----- sv/sce_pwm.sv -----
module sce_pwm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [sce_pkg::S_W-1:0]       in_e,
   input  sce_pkg::sce_side_type         in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [sce_pkg::CHAN_W-1:0]    out_chan,
   output logic [sce_pkg::COUNT_W-1:0]   out_off,
   output logic                          out_done,
   output logic                          out_last
);
   import sce_pkg::*;

   localparam int PROD_W  = POS_W + 3;
   localparam int X_W     = POS_W + 9;
   localparam int Y_W     = SCALED_W + 17;

   // stage 1: interpolated position
   logic                 a_vld_ff, a_vld_in, a_adv;
   logic [POS_W-1:0]     a_ff, a_in;
   sce_side_type         a_side_ff;
   logic signed [ANGLE_W:0]   span;
   logic signed [PROD_W-1:0]  prod, pos;

   // stage 2: scaled position
   logic                 t_vld_ff, t_vld_in, t_adv;
   logic [SCALED_W-1:0]  t_ff;
   logic [X_W-1:0]       x;
   sce_side_type         t_side_ff;

   // stage 3: output register
   logic                 o_vld_ff, o_vld_in, o_adv;
   logic [Y_W-1:0]       y;
   logic [QUOT_W:0]      sum;
   logic [COUNT_W-1:0]   off_in, off_ff;
   sce_side_type         o_side_ff;

   assign o_adv    = !o_vld_ff || out_ready;
   assign t_adv    = !t_vld_ff || o_adv;
   assign a_adv    = !a_vld_ff || t_adv;
   assign in_ready = a_adv;

   // start + (end - start) * e, or the end angle when the move is over
   always_comb begin
      span = $signed({1'b0, in_side.end_ang}) - $signed({1'b0, in_side.start_ang});
      prod = PROD_W'(span) * PROD_W'($signed({1'b0, in_e}));
      pos  = $signed({3'b000, in_side.start_ang, {FRAC_W{1'b0}}}) + prod;
      if (in_side.done) begin
         a_in = {in_side.end_ang, {FRAC_W{1'b0}}};
      end else if (pos < 0) begin
         a_in = '0;
      end else begin
         a_in = pos[POS_W-1:0];
      end
      a_vld_in = a_adv ? in_valid : a_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_ff      <= a_in;
         a_side_ff <= in_side;
      end
   end

   // position times 474, power-of-two part of the divisor dropped
   always_comb begin
      x        = {9'b0, a_ff} * {{POS_W{1'b0}}, PWM_SCALE};
      t_vld_in = t_adv ? a_vld_ff : t_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (t_adv) begin
         t_ff      <= x[SCALE_SHIFT +: SCALED_W];
         t_side_ff <= a_side_ff;
      end
   end

   // divide by 105 through the reciprocal, add offset, saturate
   always_comb begin
      y   = {17'b0, t_ff} * {{SCALED_W{1'b0}}, RECIP_105};
      sum = {1'b0, y[RECIP_SHIFT +: QUOT_W]} + PWM_OFFSET;
      if ({1'b0, sum} > PWM_MAX) begin
         off_in = PWM_MAX;
      end else begin
         off_in = {1'b0, sum};
      end
      o_vld_in = o_adv ? t_vld_ff : o_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (o_adv) begin
         off_ff    <= off_in;
         o_side_ff <= t_side_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         t_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         t_vld_ff <= t_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_chan  = o_side_ff.chan;
   assign out_off   = off_ff;
   assign out_done  = o_side_ff.done;
   assign out_last  = o_side_ff.last;

endmodule

// ----- sv/sce_checker.sv -----
module sce_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // on count and padding stay zero
   a_on_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:4] == '0) && (rsp_tdata[31:28] == '0))
      else $error("nonzero on count or padding");

   // any 12-bit angle maps to an off count between the offset and 650
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[27:16] >= 12'd73) && (rsp_tdata[27:16] <= 12'd650))
      else $error("off count out of range");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

endmodule

bind servo_cubic_ease_to_pwm sce_checker u_sce_checker (.*);
